// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// shared types for the line pixel stepper and its serial divider
// ----------------------------------------------------------------------------
package lps_pkg;

  // request from the sequencer to the divider
  typedef struct packed {
    logic start;
  } lps_div_req_t;

  // status back from the divider
  typedef struct packed {
    logic done;
  } lps_div_sts_t;

endpackage

// ===== rtl/lps_div.sv =====
// ----------------------------------------------------------------------------
// lps_div
// restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den
// ----------------------------------------------------------------------------
module lps_div import lps_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lps_div_req_t                  req_i,
  input  logic [COORD_BITS-1:0]         num_i,
  input  logic [COORD_BITS-1:0]         den_i,
  output lps_div_sts_t                  sts_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] quot_o
);

  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [QW-1:0]         dq_q, dq_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q, den_d;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;

  // one compare and subtract per cycle
  assign trial = {rem_q, dq_q[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[COORD_BITS+1];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dq_d   = dq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      cnt_d = CW'(QW);
      dq_d  = {num_i, {FRAC_BITS{1'b0}}};
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      dq_d   = {dq_q[QW-2:0], ge};
      rem_d  = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sts_o.done = done_q;
  assign quot_o     = dq_q;

endmodule

// ===== rtl/line_pixel_stepper.sv =====
// ----------------------------------------------------------------------------
// line_pixel_stepper
// steps a straight line one pixel per tick transfer, slope from a serial divide
// ----------------------------------------------------------------------------
// tick to output: a tick transfer's pixel is registered and shows on the output in the next cycle
// throughput: ticks go one per cycle while the output register drains and no divide runs
// start transfer: no divide for flat, empty or negative-major lines, otherwise
//   input is held off while the one-bit-per-cycle divider finds the slope
// reset: asynchronous, clears the line (no pixels left) and the output valid
// ----------------------------------------------------------------------------
module line_pixel_stepper import lps_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // func: 0 start a line, 1 tick
  input  logic                                  s_axis_tuser,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // pix_x, pix_y from the lowest bit up
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // last_pixel
  output logic                                  m_axis_tlast
);

  localparam int CB = COORD_BITS;
  localparam int QW = COORD_BITS + FRAC_BITS;
  // 0.4 in fixed point, rounded to nearest
  localparam int unsigned ROUND_BIAS_INT = ((32'd1 << (FRAC_BITS + 1)) + 32'd2) / 32'd5;
  localparam logic [QW-1:0] ROUND_BIAS = QW'(ROUND_BIAS_INT);

  // sequencer codes
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_DIV  = 1'b1;

  logic state_q, state_d;

  // line state
  logic [CB-1:0] major_pos_q, major_pos_d;
  logic [QW-1:0] minor_acc_q, minor_acc_d;
  logic [QW-1:0] step_inc_q,  step_inc_d;
  logic [CB-1:0] steps_left_q, steps_left_d;
  logic          y_major_q,   y_major_d;
  logic          neg_q,       neg_d;

  // output register
  logic          out_vld_q, out_vld_d;
  logic [CB-1:0] pix_x_q, pix_x_d;
  logic [CB-1:0] pix_y_q, pix_y_d;
  logic          last_q,  last_d;

  // input fields
  logic [CB-1:0] sx, sy, ex, ey;
  assign sx = s_axis_tdata[CB-1:0];
  assign sy = s_axis_tdata[2*CB-1:CB];
  assign ex = s_axis_tdata[3*CB-1:2*CB];
  assign ey = s_axis_tdata[4*CB-1:3*CB];

  // signed deltas, one bit wider than a coordinate
  logic signed [CB:0] dx, dy;
  assign dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy = $signed({1'b0, ey}) - $signed({1'b0, sy});

  // divider link
  lps_div_req_t  div_req;
  lps_div_sts_t  div_sts;
  logic [CB-1:0] div_num, div_den;
  logic [QW-1:0] div_quot;

  lps_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .num_i (div_num),
    .den_i (div_den),
    .sts_o (div_sts),
    .quot_o(div_quot)
  );

  // start decode
  logic               st_y_major;
  logic signed [CB:0] st_major, st_minor;
  logic               st_flat;
  logic               st_pos;

  always_comb begin
    st_flat = 1'b0;
    if (dx == '0) begin
      // vertical, also both deltas zero
      st_y_major = 1'b1;
      st_flat    = 1'b1;
    end else if (dy == '0) begin
      // horizontal
      st_y_major = 1'b0;
      st_flat    = 1'b1;
    end else if (dx > dy) begin
      st_y_major = 1'b0;
    end else begin
      st_y_major = 1'b1;
    end
    st_major = st_y_major ? dy : dx;
    st_minor = st_y_major ? dx : dy;
    st_pos   = (st_major > 0);
  end

  logic [CB:0]   minor_abs;
  logic [CB-1:0] minor_now;
  logic [QW-1:0] biased;
  logic          in_xfer, tick_ok;

  assign minor_abs = st_minor[CB] ? (~st_minor + 1'b1) : st_minor;
  assign div_num   = minor_abs[CB-1:0];
  assign div_den   = st_major[CB-1:0];

  assign biased    = minor_acc_q + ROUND_BIAS;
  assign minor_now = biased[QW-1:FRAC_BITS];

  // a tick needs room in the output register; a start does not
  assign tick_ok       = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = (state_q == STATE_IDLE) & (~s_axis_tuser | tick_ok);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d      = state_q;
    major_pos_d  = major_pos_q;
    minor_acc_d  = minor_acc_q;
    step_inc_d   = step_inc_q;
    steps_left_d = steps_left_q;
    y_major_d    = y_major_q;
    neg_d        = neg_q;
    out_vld_d    = out_vld_q & ~m_axis_tready;
    pix_x_d      = pix_x_q;
    pix_y_d      = pix_y_q;
    last_d       = last_q;
    div_req.start = 1'b0;

    case (state_q)
      STATE_IDLE: begin
        if (in_xfer && !s_axis_tuser) begin
          // new line replaces any in progress
          y_major_d    = st_y_major;
          major_pos_d  = st_y_major ? sy : sx;
          minor_acc_d  = {(st_y_major ? sx : sy), {FRAC_BITS{1'b0}}};
          steps_left_d = st_pos ? st_major[CB-1:0] : '0;
          step_inc_d   = '0;
          neg_d        = st_minor[CB];
          if (!st_flat && st_pos) begin
            div_req.start = 1'b1;
            state_d       = STATE_DIV;
          end
        end else if (in_xfer && steps_left_q != '0) begin
          // tick with pixels left
          out_vld_d    = 1'b1;
          pix_x_d      = y_major_q ? minor_now : major_pos_q;
          pix_y_d      = y_major_q ? major_pos_q : minor_now;
          last_d       = (steps_left_q == CB'(1));
          major_pos_d  = major_pos_q + CB'(1);
          minor_acc_d  = minor_acc_q + step_inc_q;
          steps_left_d = steps_left_q - CB'(1);
        end
      end
      STATE_DIV: begin
        if (div_sts.done) begin
          step_inc_d = neg_q ? (~div_quot + QW'(1)) : div_quot;
          state_d    = STATE_IDLE;
        end
      end
      default: state_d = STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= STATE_IDLE;
      steps_left_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      steps_left_q <= steps_left_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    major_pos_q <= major_pos_d;
    minor_acc_q <= minor_acc_d;
    step_inc_q  <= step_inc_d;
    y_major_q   <= y_major_d;
    neg_q       <= neg_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    last_q      <= last_d;
  end

  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[2*CB-1:0]  = {pix_y_q, pix_x_q};
  end
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== tb/tb_line_pixel_stepper.sv =====
// ----------------------------------------------------------------------------
// tb_line_pixel_stepper
// self-checking bench: a scoreboard steps each line alongside the block and
// compares every pixel transfer, with random idling on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_line_pixel_stepper;

  localparam int COORD_BITS   = 10;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_W        = COORD_BITS + FRAC_BITS + 2;
  // 0.4 in the fixed point format, rounded to nearest
  localparam int ROUND_BIAS   = ((1 << (FRAC_BITS + 1)) + 2) / 5;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS = 1200;
  // long output hold-off so the output register fills and ticks back up
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 150;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int S_W          = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int M_W          = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    func_e  func;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } line_cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the line state and queues the pixels each tick yields
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    coord_t                  major_pos;
    logic signed [ACC_W-1:0] minor_acc;
    logic signed [ACC_W-1:0] step_inc;
    logic [COORD_BITS:0]     steps_left;
    logic                    y_major;
    logic                    line_active;
    pixel_t                  expected_pixels[$];
    int                      errors;

    function new();
      major_pos   = '0;
      minor_acc   = '0;
      step_inc    = '0;
      steps_left  = '0;
      y_major     = 1'b0;
      line_active = 1'b0;
      errors      = 0;
    endfunction

    // minor per major step, truncated toward zero
    function logic signed [ACC_W-1:0] slope_q(logic signed [COORD_BITS+1:0] minor_d,
                                              logic signed [COORD_BITS+1:0] major_d);
      logic [COORD_BITS:0]           mag;
      logic [COORD_BITS:0]           den;
      logic [COORD_BITS+FRAC_BITS:0] quot;
      if (major_d <= 0) return '0;
      mag  = (minor_d < 0) ? (COORD_BITS+1)'(-minor_d) : (COORD_BITS+1)'(minor_d);
      den  = major_d[COORD_BITS:0];
      quot = {mag, {FRAC_BITS{1'b0}}} / den;
      return (minor_d < 0) ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    endfunction

    // called on every accepted input transfer
    function void note_command(line_cmd_t cmd);
      logic signed [COORD_BITS+1:0] dx;
      logic signed [COORD_BITS+1:0] dy;
      logic signed [COORD_BITS+1:0] major_d;
      logic [ACC_W-1:0]             biased;
      coord_t                       minor_out;
      pixel_t                       px;
      if (cmd.func == FUNC_START) begin
        dx = $signed({2'b00, cmd.ex}) - $signed({2'b00, cmd.sx});
        dy = $signed({2'b00, cmd.ey}) - $signed({2'b00, cmd.sy});
        if (dx == 0) begin
          // vertical, also the empty line when both deltas are zero
          y_major  = 1'b1;
          major_d  = dy;
          step_inc = '0;
        end else if (dy == 0) begin
          y_major  = 1'b0;
          major_d  = dx;
          step_inc = '0;
        end else if (dx > dy) begin
          y_major  = 1'b0;
          major_d  = dx;
          step_inc = slope_q(dy, dx);
        end else begin
          y_major  = 1'b1;
          major_d  = dy;
          step_inc = slope_q(dx, dy);
        end
        major_pos   = y_major ? cmd.sy : cmd.sx;
        minor_acc   = $signed({2'b00, (y_major ? cmd.sx : cmd.sy), {FRAC_BITS{1'b0}}});
        steps_left  = (major_d > 0) ? major_d[COORD_BITS:0] : '0;
        line_active = (steps_left != 0);
      end else if (line_active && steps_left != 0) begin
        // floor(acc + 0.4), wrapped to the coordinate width
        biased    = minor_acc + ACC_W'(ROUND_BIAS);
        minor_out = biased[FRAC_BITS +: COORD_BITS];
        px.x      = y_major ? minor_out : major_pos;
        px.y      = y_major ? major_pos : minor_out;
        px.last   = (steps_left == 1);
        expected_pixels.push_back(px);
        major_pos  = major_pos + 1'b1;
        minor_acc  = minor_acc + step_inc;
        steps_left = steps_left - 1'b1;
        if (steps_left == 0) line_active = 1'b0;
      end
    endfunction

    // called on every accepted output transfer
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0d",
                 $time, got.x, got.y, got.last);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x != want.x) begin
        $display("%0t: pix_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y != want.y) begin
        $display("%0t: pix_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last_pixel expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata;   // start_x, start_y, end_x, end_y
  logic           s_axis_tuser;   // func
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [M_W-1:0] m_axis_tdata;   // pix_x, pix_y
  logic           m_axis_tlast;   // last_pixel

  pixel_scoreboard sb;
  bit              send_no_idle;
  int              stall_cycles = 0;

  line_pixel_stepper #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // entered right after a rising edge; returns at the edge of the transfer
  // with tvalid still high, so a zero gap keeps the stream back to back
  task automatic send_item(line_cmd_t cmd);
    int gap;
    if ($urandom_range(0, 31) == 0) send_no_idle = !send_no_idle;
    gap = send_no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd.func;
    s_axis_tdata  <= {cmd.ey, cmd.ex, cmd.sy, cmd.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd);
  endtask

  // one start transfer followed by a run of ticks with junk endpoint fields
  task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int ticks);
    line_cmd_t cmd;
    cmd = '{func: FUNC_START, sx: sx, sy: sy, ex: ex, ey: ey};
    send_item(cmd);
    repeat (ticks) begin
      cmd.func = FUNC_TICK;
      cmd.sx   = coord_t'($urandom);
      cmd.sy   = coord_t'($urandom);
      cmd.ex   = coord_t'($urandom);
      cmd.ey   = coord_t'($urandom);
      send_item(cmd);
    end
  endtask

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // mostly well formed lines with enough ticks to finish them, a few cut
  // short by the next start, and a sprinkle of random transfers
  task automatic run_random_lines();
    int        sent;
    int        kind;
    int        dmax;
    int        dx;
    int        dy;
    int        len;
    int        ticks;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    line_cmd_t cmd;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        cmd.func = func_e'($urandom_range(0, 1));
        cmd.sx   = coord_t'($urandom);
        cmd.sy   = coord_t'($urandom);
        cmd.ex   = coord_t'($urandom);
        cmd.ey   = coord_t'($urandom);
        send_item(cmd);
        sent++;
      end else begin
        // short lines keep the run fast, a rare one spans the whole range
        dmax = (kind < 8) ? COORD_MAX : 24;
        sx   = coord_t'($urandom);
        sy   = coord_t'($urandom);
        dx   = int'($urandom_range(0, 2 * dmax)) - dmax;
        dy   = int'($urandom_range(0, 2 * dmax)) - dmax;
        if (kind % 7 == 0) dx = 0;
        else if (kind % 7 == 1) dy = 0;
        ex  = clamp_coord(int'(sx) + dx);
        ey  = clamp_coord(int'(sy) + dy);
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        len = (dx > dy) ? dx : dy;
        if (dx == 0) len = dy;
        else if (dy == 0) len = dx;
        if (len < 0) len = 0;
        ticks = len + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, len);
        // keep the total near the planned item count
        if (ticks > RANDOM_ITEMS - sent - 1) ticks = RANDOM_ITEMS - sent - 1;
        send_line(sx, sy, ex, ey, ticks);
        sent += ticks + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // output side: random ready gaps, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin : pixel_sink
    int     gap;
    int     received;
    bit     no_idle;
    bit     held;
    pixel_t got;
    m_axis_tready = 1'b0;
    received      = 0;
    no_idle       = 1'b0;
    held          = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (!held && received == HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.x    = m_axis_tdata[COORD_BITS-1:0];
      got.y    = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      got.last = m_axis_tlast;
      sb.check_pixel(got);
      received++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: no transfer on either side for too long means a hang
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_line_pixel_stepper: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    line_cmd_t cmd;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FUNC_TICK;
    s_axis_tdata  = '0;
    send_no_idle  = 1'b0;
    sb            = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick with no line yields nothing
    cmd = '{func: FUNC_TICK, sx: '0, sy: '0, ex: '0, ey: '0};
    send_item(cmd);
    // horizontal, with one tick past its end
    send_line(10'd0, 10'd5, 10'd3, 10'd5, 4);
    // vertical
    send_line(10'd7, 10'd0, 10'd7, 10'd2, 3);
    // both deltas zero
    send_line(10'd3, 10'd3, 10'd3, 10'd3, 1);
    // negative major delta
    send_line(10'd10, 10'd2, 10'd5, 10'd2, 1);
    // x major with a shallow slope
    send_line(10'd0, 10'd0, 10'd3, 10'd1, 3);
    // y major with x falling
    send_line(10'd1, 10'd0, 10'd0, 10'd3, 3);
    // full range line, cut short by the next start
    send_line(10'd0, 10'd1023, 10'd1023, 10'd0, 2);
    send_line(10'd1023, 10'd1023, 10'd0, 10'd0, 1);

    run_random_lines();
    s_axis_tvalid <= 1'b0;

    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb_line_pixel_stepper: done, clean");
    end else begin
      $display("tb_line_pixel_stepper: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lps_pkg.sv
rtl/lps_div.sv
rtl/line_pixel_stepper.sv
tb/tb_line_pixel_stepper.sv
